// ===== src/lss_pkg.sv =====
// Shared types, register indexes and rotation constants for the scan segmenter.
package lss_pkg;

  localparam logic [3:0] REG_RANGE_LOW   = 4'd0;
  localparam logic [3:0] REG_RANGE_HIGH  = 4'd1;
  localparam logic [3:0] REG_START_ANGLE = 4'd2;
  localparam logic [3:0] REG_ANGLE_STEP  = 4'd3;
  localparam logic [3:0] REG_GAP_RATIO   = 4'd4;
  localparam logic [3:0] REG_GAP_FLOOR   = 4'd5;
  localparam logic [3:0] REG_GAP_CEILING = 4'd6;
  localparam logic [3:0] REG_COS_LIMIT   = 4'd7;

  localparam int unsigned SEG_MAX = 2047;
  localparam int unsigned BRK_MAX = 4095;

  typedef struct packed {
    logic        [15:0] range_low;
    logic        [15:0] range_high;
    logic signed [15:0] start_angle;
    logic        [11:0] angle_step;
    logic        [11:0] gap_ratio;
    logic        [15:0] gap_floor;
    logic        [15:0] gap_ceiling;
    logic signed [15:0] cos_angle_limit;
  } cfg_t;

  // micro-rotation angles, 2^-24 turn
  function automatic logic signed [24:0] rot_angle(input logic [3:0] i);
    logic signed [24:0] v;
    case (i)
      4'd0:    v = 25'sd2097152;
      4'd1:    v = 25'sd1238021;
      4'd2:    v = 25'sd654136;
      4'd3:    v = 25'sd332050;
      4'd4:    v = 25'sd166669;
      4'd5:    v = 25'sd83416;
      4'd6:    v = 25'sd41718;
      4'd7:    v = 25'sd20860;
      4'd8:    v = 25'sd10430;
      4'd9:    v = 25'sd5215;
      4'd10:   v = 25'sd2608;
      4'd11:   v = 25'sd1304;
      4'd12:   v = 25'sd652;
      4'd13:   v = 25'sd326;
      4'd14:   v = 25'sd163;
      default: v = 25'sd81;
    endcase
    return v;
  endfunction

endpackage

// ===== src/lss_front.sv =====
// Front end: takes samples, windows the range and converts to x, y by iterative CORDIC.
module lss_front #(
  parameter int MAX_SAMPLES = 2048,
  parameter int COORD_BITS  = 17,
  localparam int JW = 2 * COORD_BITS + 18
) (
  input  logic              clk,
  input  logic              rst,
  input  lss_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       range,
  input  logic              final_sample,
  output logic              push,
  output logic [JW-1:0]     push_data,
  input  logic              full
);
  import lss_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int WE = ((CB > 27) ? CB : 27) + 1;
  localparam logic signed [WE-1:0] LIM = WE'((64'sd1 <<< (CB - 1)) - 64'sd1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_ROT  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t            state;
  logic [IW-1:0]      idx;
  logic [3:0]         it;
  logic               pt, fin, flip;
  logic [15:0]        r;
  logic signed [26:0] x, y;
  logic signed [24:0] z;

  logic               ok;
  logic [27:0]        stepx;
  logic [15:0]        ang, angf;
  logic [31:0]        prod;
  logic signed [26:0] xs, ys, xr, yr;
  logic signed [WE-1:0] xe, ye;
  logic signed [CB-1:0] xo, yo;

  assign in_ready = (state == F_IDLE);
  assign ok    = (range >= cfg.range_low) && (range <= cfg.range_high);
  assign stepx = 28'(cfg.angle_step) * 28'(idx);
  assign ang   = cfg.start_angle + stepx[15:0];
  assign angf  = (ang[15] ^ ang[14]) ? (ang ^ 16'h8000) : ang;
  assign prod  = 32'(range) * 32'd39797;
  assign xs    = x >>> it;
  assign ys    = y >>> it;

  always_comb begin
    xr = (x + 27'sd128) >>> 8;
    yr = (y + 27'sd128) >>> 8;
    if (flip) begin
      xr = -xr;
      yr = -yr;
    end
    xe = WE'(xr);
    ye = WE'(yr);
    if (xe > LIM) xe = LIM;
    else if (xe < -LIM) xe = -LIM;
    if (ye > LIM) ye = LIM;
    else if (ye < -LIM) ye = -LIM;
    xo = xe[CB-1:0];
    yo = ye[CB-1:0];
  end

  assign push      = (state == F_PUSH) && !full;
  assign push_data = {pt, fin, xo, yo, r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            pt   <= ok;
            fin  <= final_sample;
            r    <= range;
            flip <= ang[15] ^ ang[14];
            x    <= {3'b000, prod[31:8]};
            y    <= '0;
            z    <= {angf[15], angf, 8'd0};
            it   <= '0;
            if (final_sample) idx <= '0;
            else if (idx == IW'(MAX_SAMPLES - 1)) idx <= '0;
            else idx <= idx + 1'b1;
            state <= ok ? F_ROT : F_PUSH;
          end
        end
        F_ROT: begin
          if (!z[24]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - rot_angle(it);
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + rot_angle(it);
          end
          it <= it + 1'b1;
          if (it == 4'd15) state <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== src/lss_queue.sv =====
// Two-word queue between the front and back ends.
module lss_queue #(
  parameter int W = 52
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wp, rp;
  logic [1:0]   cnt;

  assign full     = (cnt == 2'd2);
  assign empty    = (cnt == 2'd0);
  assign pop_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ===== src/lss_back.sv =====
// Back end: pair tests, segment counting and result output register.
module lss_back #(
  parameter int COORD_BITS = 17,
  localparam int JW = 2 * COORD_BITS + 18
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lss_pkg::cfg_t                cfg,
  input  logic                         empty,
  input  logic [JW-1:0]                pop_data,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         point_valid,
  output logic signed [COORD_BITS-1:0] x_mm,
  output logic signed [COORD_BITS-1:0] y_mm,
  output logic [10:0]                  segment,
  output logic                         joined_to_next,
  output logic                         end_of_scan,
  output logic                         first_joins_last,
  output logic                         single_segment
);
  import lss_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int AW = ((2 * CB + 16 > 49) ? 2 * CB + 16 : 49) + 1;
  localparam int LW = ((2 * CB + 19 > 56) ? 2 * CB + 19 : 56) + 1;

  typedef enum logic [3:0] {
    S_FETCH = 4'b0001,
    S_TEST  = 4'b0010,
    S_EMIT  = 4'b0100,
    S_CLOSE = 4'b1000
  } bstate_t;

  bstate_t state;
  logic [1:0] step;
  logic closing, emitted, have_prev;
  logic [10:0] seg_cnt;
  logic [11:0] brk_cnt;

  logic               jfin;
  logic signed [CB-1:0] jx, jy, px, py, fx, fy;
  logic [15:0]        jr, pr, fr;

  logic               q_pt, q_fin;
  logic signed [CB-1:0] q_x, q_y;
  logic [15:0]        q_r;

  logic signed [CB-1:0] bx, by;
  logic [15:0]        br, rmin;

  logic signed [2*CB-1:0] pxx, pyy;
  logic [31:0]        prr;
  logic [27:0]        mraw, mcl, mcl_next;
  logic signed [CB:0] dx, dy;
  logic signed [2*CB:0] dot;
  logic signed [48:0] rhs;
  logic signed [2*CB+1:0] dxx, dyy;
  logic [2*CB+2:0]    l2;
  logic [55:0]        mm;
  logic               afail, jres;
  logic               slot_free, single_pt;
  logic [12:0]        brk_tot;

  assign {q_pt, q_fin, q_x, q_y, q_r} = pop_data;
  assign pop       = (state == S_FETCH) && !empty;
  assign slot_free = !out_valid || out_ready;

  assign bx   = closing ? fx : jx;
  assign by   = closing ? fy : jy;
  assign br   = closing ? fr : jr;
  assign rmin = (pr < br) ? pr : br;

  assign single_pt = !emitted && (brk_cnt == '0) && (seg_cnt == '0) &&
                     (px == fx) && (py == fy) && (pr == fr);
  assign brk_tot = {1'b0, brk_cnt} + {12'd0, !jres};

  always_comb begin
    mcl_next = mraw;
    if (mraw < {4'd0, cfg.gap_floor, 8'd0}) mcl_next = {4'd0, cfg.gap_floor, 8'd0};
    else if (mraw > {4'd0, cfg.gap_ceiling, 8'd0}) mcl_next = {4'd0, cfg.gap_ceiling, 8'd0};
  end

  // pair test datapath, one stage per step
  always_ff @(posedge clk) begin
    if (state == S_TEST) begin
      case (step)
        2'd0: begin
          pxx  <= px * bx;
          pyy  <= py * by;
          prr  <= 32'(pr) * 32'(br);
          mraw <= 28'(rmin) * 28'(cfg.gap_ratio);
          dx   <= (CB+1)'(px) - (CB+1)'(bx);
          dy   <= (CB+1)'(py) - (CB+1)'(by);
        end
        2'd1: begin
          dot <= (2*CB+1)'(pxx) + (2*CB+1)'(pyy);
          rhs <= 49'(cfg.cos_angle_limit) * $signed({17'd0, prr});
          dxx <= dx * dx;
          dyy <= dy * dy;
          mcl <= mcl_next;
        end
        2'd2: begin
          afail <= $signed({{(AW-2*CB-16){dot[2*CB]}}, dot, 15'd0}) <
                   $signed({{(AW-49){rhs[48]}}, rhs});
          l2    <= (2*CB+3)'(dxx[2*CB+1:0]) + (2*CB+3)'(dyy[2*CB+1:0]);
          mm    <= 56'(mcl) * 56'(mcl);
        end
        default: begin
          jres <= !afail &&
                  !(LW'({l2, 16'd0}) > LW'(mm));
        end
      endcase
    end else if (state == S_CLOSE) begin
      jres <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FETCH;
      step      <= '0;
      closing   <= 1'b0;
      emitted   <= 1'b0;
      have_prev <= 1'b0;
      seg_cnt   <= '0;
      brk_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_FETCH: begin
          if (!empty) begin
            jfin    <= q_fin;
            jx      <= q_x;
            jy      <= q_y;
            jr      <= q_r;
            emitted <= 1'b0;
            closing <= 1'b0;
            step    <= '0;
            if (q_pt && have_prev) begin
              state <= S_TEST;
            end else begin
              if (q_pt) begin
                fx <= q_x; fy <= q_y; fr <= q_r;
                px <= q_x; py <= q_y; pr <= q_r;
                have_prev <= 1'b1;
              end
              state <= q_fin ? S_CLOSE : S_FETCH;
            end
          end
        end
        S_TEST: begin
          step <= step + 1'b1;
          if (step == 2'd3) state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid      <= 1'b1;
            point_valid    <= 1'b1;
            x_mm           <= px;
            y_mm           <= py;
            segment        <= seg_cnt;
            joined_to_next <= jres;
            if (!closing) begin
              end_of_scan      <= 1'b0;
              first_joins_last <= 1'b0;
              single_segment   <= 1'b0;
              if (!jres) begin
                if (brk_cnt != 12'(BRK_MAX)) brk_cnt <= brk_cnt + 1'b1;
                if (seg_cnt != 11'(SEG_MAX)) seg_cnt <= seg_cnt + 1'b1;
              end
              px <= jx; py <= jy; pr <= jr;
              emitted <= 1'b1;
              state   <= jfin ? S_CLOSE : S_FETCH;
            end else begin
              end_of_scan      <= 1'b1;
              first_joins_last <= jres;
              single_segment   <= (brk_tot <= 13'd1);
              have_prev <= 1'b0;
              seg_cnt   <= '0;
              brk_cnt   <= '0;
              state     <= S_FETCH;
            end
          end
        end
        S_CLOSE: begin
          closing <= 1'b1;
          step    <= '0;
          if (!have_prev) begin
            if (slot_free) begin
              out_valid        <= 1'b1;
              point_valid      <= 1'b0;
              x_mm             <= '0;
              y_mm             <= '0;
              segment          <= '0;
              joined_to_next   <= 1'b0;
              end_of_scan      <= 1'b1;
              first_joins_last <= 1'b0;
              single_segment   <= 1'b0;
              seg_cnt          <= '0;
              brk_cnt          <= '0;
              state            <= S_FETCH;
            end
          end else if (single_pt) begin
            state <= S_EMIT;
          end else begin
            state <= S_TEST;
          end
        end
        default: state <= S_FETCH;
      endcase
    end
  end

endmodule

// ===== src/lidar_scan_segmenter_unit.sv =====
// Top level of the lidar scan segmenter: config registers, front end, queue, back end.
//
//  channel  handshake              word
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//  in       in_valid / in_ready    range, final_sample
//  out      out_valid / out_ready  point_valid .. single_segment
//
// The front end accepts a sample, runs 16 CORDIC micro-rotations and hands the point
// to the queue, waiting while it is full, before it takes the next sample; a sample
// outside the range window skips the rotations. The back end fetches a word, runs a
// pair test and writes a result word; a final sample with a point that is not the first
// point of the scan costs two tests. The two-word queue lets the front convert the next
// sample while the back end waits on out_ready.
// Synchronous reset clears all control state and loads register defaults.
module lidar_scan_segmenter_unit #(
  parameter int MAX_SAMPLES = 2048,
  parameter int COORD_BITS  = 17
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [3:0]                   cfg_index,
  input  logic [15:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [15:0]                  range,
  input  logic                         final_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         point_valid,
  output logic signed [COORD_BITS-1:0] x_mm,
  output logic signed [COORD_BITS-1:0] y_mm,
  output logic [10:0]                  segment,
  output logic                         joined_to_next,
  output logic                         end_of_scan,
  output logic                         first_joins_last,
  output logic                         single_segment
);
  import lss_pkg::*;

  localparam int JW = 2 * COORD_BITS + 18;

  cfg_t          cfg;
  logic          push, full, pop, empty;
  logic [JW-1:0] push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_low       <= 16'd0;
      cfg.range_high      <= 16'd65535;
      cfg.start_angle     <= 16'sd0;
      cfg.angle_step      <= 12'd182;
      cfg.gap_ratio       <= 12'd512;
      cfg.gap_floor       <= 16'd100;
      cfg.gap_ceiling     <= 16'd800;
      cfg.cos_angle_limit <= 16'sd31164;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RANGE_LOW:   cfg.range_low       <= cfg_data;
        REG_RANGE_HIGH:  cfg.range_high      <= cfg_data;
        REG_START_ANGLE: cfg.start_angle     <= cfg_data;
        REG_ANGLE_STEP:  cfg.angle_step      <= cfg_data[11:0];
        REG_GAP_RATIO:   cfg.gap_ratio       <= cfg_data[11:0];
        REG_GAP_FLOOR:   cfg.gap_floor       <= cfg_data;
        REG_GAP_CEILING: cfg.gap_ceiling     <= cfg_data;
        REG_COS_LIMIT:   cfg.cos_angle_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  lss_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .range       (range),
    .final_sample(final_sample),
    .push        (push),
    .push_data   (push_data),
    .full        (full)
  );

  lss_queue #(
    .W(JW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (empty)
  );

  lss_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .empty           (empty),
    .pop_data        (pop_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .point_valid     (point_valid),
    .x_mm            (x_mm),
    .y_mm            (y_mm),
    .segment         (segment),
    .joined_to_next  (joined_to_next),
    .end_of_scan     (end_of_scan),
    .first_joins_last(first_joins_last),
    .single_segment  (single_segment)
  );

endmodule
